### rtl/pip_pkg.sv
`default_nettype none
package pip_pkg;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int CoordW = 16;
  localparam int CountW = 7;
  localparam logic [CountW-1:0] CountReset = 7'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic                     vld;
    logic                     last;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
  } edge_req_t;

  typedef struct packed {
    logic done;
    logic parity;
  } edge_sts_t;

endpackage
`default_nettype wire

### rtl/point_in_polygon_test.sv
`default_nettype none
// Crossing-number point-in-polygon test on signed 16-bit grid coordinates.
// Items enter on start while busy is low. func = load writes coord_x/coord_y
// into the vertex store at vertex_index in the accepting cycle (indexes at or
// beyond MAX_VERTICES are dropped); a load gives no result and never raises
// busy. func = query latches the point and walks the closed polygon made of
// the first vertex_count stored vertices, one edge per cycle.
// Config beat: cfg_valid/cfg_ready carry vertex_count (0 acts as 1, values
// above MAX_VERTICES saturate); cfg_ready is high while the block is idle.
// A query runs in this order: the single read port of the vertex store
// returns one vertex per cycle (N reads, N being the vertex count in use),
// the closing edge back to the first vertex follows the last read, and each
// edge passes the three-stage edge pipeline (differences, cross products,
// compare and parity); done then rises with inside_res. busy falls in the
// cycle after done, and only then can the next item be accepted.
// done is high for exactly one cycle with inside_res; the receiver cannot
// stall and the result is lost if not taken then.
// Reset clears control state and sets vertex_count to 3; the vertex store is
// undefined until written and needs no clearing pass.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output      logic                                 busy,
  input  wire logic                                 func,
  input  wire logic [5:0]                           vertex_index,
  input  wire logic signed [pip_pkg::CoordW-1:0]    coord_x,
  input  wire logic signed [pip_pkg::CoordW-1:0]    coord_y,
  output      logic                                 done,
  output      logic                                 inside_res,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [pip_pkg::CountW-1:0]           vertex_count
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VW = 2 * pip_pkg::CoordW;

  pip_pkg::state_t state, state_next;

  logic [pip_pkg::CountW-1:0] vcount;
  int                         n_use;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              rd_idx;
  logic                       rd_en;

  logic                       accept, do_load, do_query;
  logic                       ram_we;
  logic [VW-1:0]              rdata;

  logic                       ret_vld, ret_first, ret_last, close_pend;
  logic signed [pip_pkg::CoordW-1:0] px, py, v0x, v0y, prvx, prvy;
  logic signed [pip_pkg::CoordW-1:0] rx, ry;

  pip_pkg::edge_req_t req;
  pip_pkg::edge_sts_t sts;

  assign accept   = start & ~busy;
  assign do_load  = accept & (func == pip_pkg::FUNC_LOAD);
  assign do_query = accept & (func == pip_pkg::FUNC_QUERY);
  assign ram_we   = do_load & (int'(vertex_index) < MAX_VERTICES);

  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= pip_pkg::CountReset;
    end else if (cfg_valid && cfg_ready) begin
      vcount <= vertex_count;
    end
  end

  always_comb begin
    if (vcount == '0) begin
      n_use = 1;
    end else if (int'(vcount) > MAX_VERTICES) begin
      n_use = MAX_VERTICES;
    end else begin
      n_use = int'(vcount);
    end
  end

  assign last_idx = AW'(n_use - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      pip_pkg::ST_IDLE: if (do_query) state_next = pip_pkg::ST_WALK;
      pip_pkg::ST_WALK: if (rd_idx == last_idx) state_next = pip_pkg::ST_WAIT;
      pip_pkg::ST_WAIT: if (sts.done) state_next = pip_pkg::ST_IDLE;
      default:          state_next = pip_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != pip_pkg::ST_IDLE);
    rd_en = (state == pip_pkg::ST_WALK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pip_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      rd_idx <= '0;
      px     <= coord_x;
      py     <= coord_y;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  pip_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(vertex_index)),
    .wdata({coord_y, coord_x}),
    .re   (rd_en),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ret_vld    <= 1'b0;
      ret_first  <= 1'b0;
      ret_last   <= 1'b0;
      close_pend <= 1'b0;
    end else begin
      ret_vld    <= rd_en;
      ret_first  <= rd_en & (rd_idx == '0);
      ret_last   <= rd_en & (rd_idx == last_idx);
      close_pend <= ret_vld & ret_last;
    end
  end

  assign rx = rdata[pip_pkg::CoordW-1:0];
  assign ry = rdata[VW-1:pip_pkg::CoordW];

  always_ff @(posedge clk) begin
    if (ret_vld) begin
      prvx <= rx;
      prvy <= ry;
      if (ret_first) begin
        v0x <= rx;
        v0y <= ry;
      end
    end
  end

  always_comb begin
    req.vld  = (ret_vld & ~ret_first) | close_pend;
    req.last = close_pend;
    req.px   = px;
    req.py   = py;
    req.x1   = prvx;
    req.y1   = prvy;
    req.x2   = close_pend ? v0x : rx;
    req.y2   = close_pend ? v0y : ry;
  end

  pip_edge u_edge (
    .clk  (clk),
    .rst  (rst),
    .clear(do_query),
    .req  (req),
    .sts  (sts)
  );

  assign done       = sts.done;
  assign inside_res = sts.parity;

endmodule
`default_nettype wire

### rtl/pip_ram.sv
`default_nettype none
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/pip_edge.sv
`default_nettype none
module pip_edge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               clear,
  input  wire pip_pkg::edge_req_t req,
  output      pip_pkg::edge_sts_t sts
);

  localparam int DW = pip_pkg::CoordW + 1;
  localparam int PW = 2 * DW;

  logic signed [pip_pkg::CoordW-1:0] px, py, x1, y1, x2, y2;
  logic signed [pip_pkg::CoordW-1:0] ylo, yhi, xhi;
  logic                              in_band;

  logic                 s1_vld, s1_last, s1_band, s1_vert, s1_dpos;
  logic signed [DW-1:0] s1_dx, s1_d, s1_dy, s1_ex;

  logic                 s2_vld, s2_last, s2_band, s2_vert, s2_dpos;
  logic signed [PW-1:0] s2_lhs, s2_rhs;
  logic                 hit;

  logic parity;
  logic fin;

  assign px = req.px;
  assign py = req.py;
  assign x1 = req.x1;
  assign y1 = req.y1;
  assign x2 = req.x2;
  assign y2 = req.y2;

  assign ylo     = (y1 < y2) ? y1 : y2;
  assign yhi     = (y1 < y2) ? y2 : y1;
  assign xhi     = (x1 < x2) ? x2 : x1;
  assign in_band = (py > ylo) && (py <= yhi) && (px <= xhi);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s1_last <= 1'b0;
    end else begin
      s1_vld  <= req.vld;
      s1_last <= req.vld & req.last;
    end
  end

  always_ff @(posedge clk) begin
    s1_band <= in_band;
    s1_vert <= (x1 == x2);
    s1_dpos <= (y2 > y1);
    s1_dx   <= {px[pip_pkg::CoordW-1], px} - {x1[pip_pkg::CoordW-1], x1};
    s1_d    <= {y2[pip_pkg::CoordW-1], y2} - {y1[pip_pkg::CoordW-1], y1};
    s1_dy   <= {py[pip_pkg::CoordW-1], py} - {y1[pip_pkg::CoordW-1], y1};
    s1_ex   <= {x2[pip_pkg::CoordW-1], x2} - {x1[pip_pkg::CoordW-1], x1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld  <= 1'b0;
      s2_last <= 1'b0;
    end else begin
      s2_vld  <= s1_vld;
      s2_last <= s1_vld & s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s2_band <= s1_band;
    s2_vert <= s1_vert;
    s2_dpos <= s1_dpos;
    s2_lhs  <= s1_dx * s1_d;
    s2_rhs  <= s1_dy * s1_ex;
  end

  assign hit = s2_band &
               (s2_vert | (s2_dpos ? (s2_lhs <= s2_rhs) : (s2_lhs >= s2_rhs)));

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      fin    <= 1'b0;
    end else begin
      fin <= s2_vld & s2_last;
      if (clear) begin
        parity <= 1'b0;
      end else if (s2_vld && hit) begin
        parity <= ~parity;
      end
    end
  end

  assign sts.done   = fin;
  assign sts.parity = parity;

endmodule
`default_nettype wire
